FILE: rtl/dijkstra_shortest_paths_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shortest path unit
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DIJKSTRA_SHORTEST_PATHS_UNIT_DEFINES_SVH
`define DIJKSTRA_SHORTEST_PATHS_UNIT_DEFINES_SVH

// Same-cycle implication.
`define DSP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shortest path unit assertion failed");

// Next-cycle implication.
`define DSP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shortest path unit assertion failed");

`endif

FILE: rtl/dsp_pkg.sv
// ----------------------------------------------------------------------------
// Shortest path unit package
// Command and result types, mode codes, register indexes and unit opcodes.
// ----------------------------------------------------------------------------
package dsp_pkg;

	localparam int DIST_W = 32;
	localparam int VTX_W = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [1:0] MODE_LOAD_OFFSET = 2'd0;
	localparam logic [1:0] MODE_LOAD_EDGE = 2'd1;
	localparam logic [1:0] MODE_RUN = 2'd2;
	localparam logic [1:0] MODE_READ = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_VERTEX = 2'd1;

	localparam logic ALU_ADD_SAT = 1'b0;
	localparam logic ALU_LESS = 1'b1;

	localparam logic KIND_RUN_DONE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic [1:0] mode;
		logic [9:0] vertex_index;
		logic [12:0] edge_end_offset;
		logic [11:0] edge_index;
		logic [9:0] edge_target;
		logic [31:0] edge_weight;
	} cmd_t;

	typedef struct packed {
		logic result_kind;
		logic [31:0] distance;
		logic [9:0] predecessor;
		logic predecessor_valid;
		logic [10:0] settled_count;
	} result_t;

endpackage

FILE: rtl/dsp_alu.sv
// ----------------------------------------------------------------------------
// Shortest path unit arithmetic
// Shared saturating adder and less-than comparator for distance values.
// ----------------------------------------------------------------------------
module dsp_alu (
	input  logic                      op,
	input  logic [dsp_pkg::DIST_W-1:0] a,
	input  logic [dsp_pkg::DIST_W-1:0] b,
	output logic [dsp_pkg::DIST_W-1:0] sum,
	output logic                      less
);
	import dsp_pkg::*;

	logic [DIST_W:0] wide;

	always_comb begin
		wide = {1'b0, a} + {1'b0, b};
		sum = '0;
		less = 1'b0;
		unique case (op)
			ALU_ADD_SAT: begin
				// A sum that reaches the unreached value stops one below it.
				if (wide >= {1'b0, {DIST_W{1'b1}}}) begin
					sum = {{(DIST_W-1){1'b1}}, 1'b0};
				end else begin
					sum = wide[DIST_W-1:0];
				end
			end
			ALU_LESS: begin
				less = a < b;
			end
			default: begin
				sum = '0;
			end
		endcase
	end
endmodule

FILE: rtl/dijkstra_shortest_paths_unit.sv
// ----------------------------------------------------------------------------
// Dijkstra shortest path unit
// Loads a compressed sparse row graph, runs single-source shortest paths
// with a binary min-heap and answers per-vertex distance reads.
// ----------------------------------------------------------------------------
// Usage: a command transaction is taken at a rising edge with start high and
// busy low. Offset and edge loads write one memory entry and leave busy low,
// so they stream at one per cycle and return nothing. A read holds busy in
// S_RD ahead of its registered result. A run clears the distance, predecessor
// and heap memories, then walks the heap. Each pop reads in S_POP0 and S_POP1,
// and its sift-down runs S_SD0 to S_SD2 per child compare, S_SD0 writing the
// entry when it rests as a leaf. Each settled vertex reads its offsets in S_E0
// to S_E2 and exits from S_E3. An edge ends at S_E4 for an out-of-range
// target, S_E5 for a settled one, S_E6 with no shorter path, else it sifts up
// through S_SU0 and S_SU1 per level. Busy stays high until the cycle that
// carries the run result. The result is on result for the single cycle that
// result_valid is high; the receiver cannot stall it. Registers are written
// through cfg_valid and cfg_ready, which is always high; writes must happen
// only while the unit is idle, which it does not enforce. After reset a
// clearing pass over all MAX_VERTICES entries keeps busy high.
// ----------------------------------------------------------------------------
`include "dijkstra_shortest_paths_unit_defines.svh"

module dijkstra_shortest_paths_unit #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  dsp_pkg::cmd_t                 cmd,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dsp_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                          result_valid,
	output dsp_pkg::result_t              result
);
	import dsp_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int NW = VW + 1;
	localparam int LW = VW + 2;
	localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EN = EW + 1;
	localparam int HEW = DIST_W + VW;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_CLR = 5'd1;
	localparam logic [4:0] S_RD = 5'd2;
	localparam logic [4:0] S_DONE = 5'd3;
	localparam logic [4:0] S_POP0 = 5'd4;
	localparam logic [4:0] S_POP1 = 5'd5;
	localparam logic [4:0] S_SD0 = 5'd6;
	localparam logic [4:0] S_SD1 = 5'd7;
	localparam logic [4:0] S_SD2 = 5'd8;
	localparam logic [4:0] S_E0 = 5'd9;
	localparam logic [4:0] S_E1 = 5'd10;
	localparam logic [4:0] S_E2 = 5'd11;
	localparam logic [4:0] S_E3 = 5'd12;
	localparam logic [4:0] S_E4 = 5'd13;
	localparam logic [4:0] S_E5 = 5'd14;
	localparam logic [4:0] S_E6 = 5'd15;
	localparam logic [4:0] S_SU0 = 5'd16;
	localparam logic [4:0] S_SU1 = 5'd17;

	localparam logic [DIST_W-1:0] UNREACHED = {DIST_W{1'b1}};

	logic [4:0] state_q;
	logic [10:0] vcount_q;
	logic [VTX_W-1:0] src_q;
	logic run_q;
	logic [VW-1:0] clr_q;
	logic [NW-1:0] hs_q;
	logic [NW-1:0] settled_q;
	logic [VW-1:0] top_q;
	logic [DIST_W-1:0] c_q;
	logic [HEW-1:0] e_q;
	logic [VW-1:0] i_q;
	logic [LW-1:0] l_q;
	logic [HEW-1:0] ch_q;
	logic [VW-1:0] ci_q;
	logic [VW-1:0] p_q;
	logic [EN-1:0] j_q;
	logic [EN-1:0] end_q;
	logic [VTX_W-1:0] t_q;
	logic [DIST_W-1:0] w_q;
	logic [DIST_W-1:0] sum_q;
	logic [DIST_W-1:0] dt_q;
	logic [VW-1:0] pt_q;
	logic rd_oor_q;
	logic res_valid_q;
	result_t res_q;

	logic [12:0] off_mem [MAX_VERTICES];
	logic [VTX_W-1:0] tgt_mem [MAX_EDGES];
	logic [DIST_W-1:0] wgt_mem [MAX_EDGES];
	logic [DIST_W-1:0] dist_mem [MAX_VERTICES];
	logic [VW:0] pred_mem [MAX_VERTICES];
	logic [HEW-1:0] heap_mem [MAX_VERTICES];
	logic [VW:0] pos_mem [MAX_VERTICES];

	logic off_we, edge_we, dist_we, pred_we, heap_we, pos_we;
	logic [VW-1:0] off_wa, off_ra, dist_wa, dist_ra, pred_wa, pred_ra;
	logic [VW-1:0] heap_wa, heap_ra_a, heap_ra_b, pos_wa, pos_ra;
	logic [EW-1:0] edge_wa, edge_ra;
	logic [DIST_W-1:0] dist_wd;
	logic [VW:0] pred_wd, pos_wd;
	logic [HEW-1:0] heap_wd;
	logic [12:0] off_rd;
	logic [VTX_W-1:0] tgt_rd;
	logic [DIST_W-1:0] wgt_rd, dist_rd;
	logic [VW:0] pred_rd, pos_rd;
	logic [HEW-1:0] heap_rd_a, heap_rd_b;

	logic alu_op;
	logic [DIST_W-1:0] alu_a, alu_b, alu_sum;
	logic alu_less;

	logic [31:0] n_full;
	logic [NW-1:0] n_w;
	logic src_ok;
	logic [VW-1:0] src_v;
	logic accept;
	logic [LW-1:0] l_w, l1_w;
	logic [VW-1:0] clr_slot;
	logic [EN-1:0] off_clamp;

	assign cfg_ready = 1'b1;
	assign busy = state_q != S_IDLE;
	assign accept = start && !busy;
	assign result_valid = res_valid_q;
	assign result = res_q;

	assign n_full = (32'(vcount_q) > MAX_VERTICES) ? MAX_VERTICES : 32'(vcount_q);
	assign n_w = NW'(n_full);
	assign src_ok = 32'(src_q) < n_full;
	assign src_v = VW'(src_q);
	assign l_w = LW'({i_q, 1'b1});
	assign l1_w = l_w + LW'(1);
	assign off_clamp = (32'(off_rd) > MAX_EDGES) ? EN'(MAX_EDGES) : EN'(off_rd);

	always_comb begin
		if (src_ok && clr_q == '0) begin
			clr_slot = src_v;
		end else if (src_ok && clr_q == src_v) begin
			clr_slot = '0;
		end else begin
			clr_slot = clr_q;
		end
	end

	dsp_alu u_alu (
		.op   (alu_op),
		.a    (alu_a),
		.b    (alu_b),
		.sum  (alu_sum),
		.less (alu_less)
	);

	always_comb begin
		alu_op = ALU_LESS;
		alu_a = '0;
		alu_b = '0;
		unique case (state_q)
			S_SD1: begin
				alu_a = heap_rd_b[HEW-1:VW];
				alu_b = heap_rd_a[HEW-1:VW];
			end
			S_SD2: begin
				alu_a = ch_q[HEW-1:VW];
				alu_b = e_q[HEW-1:VW];
			end
			S_E5: begin
				alu_op = ALU_ADD_SAT;
				alu_a = c_q;
				alu_b = w_q;
			end
			S_E6: begin
				alu_a = sum_q;
				alu_b = dt_q;
			end
			S_SU1: begin
				alu_a = e_q[HEW-1:VW];
				alu_b = heap_rd_a[HEW-1:VW];
			end
			default: begin
				alu_op = ALU_LESS;
			end
		endcase
	end

	always_comb begin
		off_we = 1'b0;
		edge_we = 1'b0;
		dist_we = 1'b0;
		pred_we = 1'b0;
		heap_we = 1'b0;
		pos_we = 1'b0;
		off_wa = VW'(cmd.vertex_index);
		edge_wa = EW'(cmd.edge_index);
		dist_wa = clr_q;
		pred_wa = clr_q;
		heap_wa = i_q;
		pos_wa = clr_q;
		dist_wd = UNREACHED;
		pred_wd = {1'b1, {VW{1'b0}}};
		heap_wd = e_q;
		pos_wd = {1'b0, i_q};
		off_ra = top_q;
		edge_ra = j_q[EW-1:0];
		dist_ra = VW'(cmd.vertex_index);
		pred_ra = VW'(cmd.vertex_index);
		heap_ra_a = '0;
		heap_ra_b = '0;
		pos_ra = VW'(t_q);
		unique case (state_q)
			S_IDLE: begin
				if (accept && cmd.mode == MODE_LOAD_OFFSET) begin
					off_we = 32'(cmd.vertex_index) < MAX_VERTICES;
				end
				if (accept && cmd.mode == MODE_LOAD_EDGE) begin
					edge_we = 32'(cmd.edge_index) < MAX_EDGES;
				end
			end
			S_CLR: begin
				dist_we = 1'b1;
				pred_we = 1'b1;
				heap_we = 1'b1;
				pos_we = 1'b1;
				heap_wa = clr_q;
				dist_wd = (run_q && src_ok && clr_q == src_v) ? '0 : UNREACHED;
				heap_wd = {((src_ok && clr_slot == src_v) ? {DIST_W{1'b0}} : UNREACHED),
					clr_slot};
				pos_wd = {1'b0, clr_slot};
			end
			S_POP0: begin
				heap_ra_a = '0;
				heap_ra_b = VW'(hs_q - NW'(1));
			end
			S_POP1: begin
				pos_we = 1'b1;
				pos_wa = heap_rd_a[VW-1:0];
				pos_wd = {1'b1, {VW{1'b0}}};
			end
			S_SD0: begin
				heap_ra_a = l_w[VW-1:0];
				heap_ra_b = l1_w[VW-1:0];
				if (LW'(hs_q) <= l_w) begin
					heap_we = 1'b1;
					pos_we = 1'b1;
					pos_wa = e_q[VW-1:0];
				end
			end
			S_SD2: begin
				heap_we = 1'b1;
				pos_we = 1'b1;
				if (alu_less) begin
					heap_wd = ch_q;
					pos_wa = ch_q[VW-1:0];
				end else begin
					pos_wa = e_q[VW-1:0];
				end
			end
			S_E1: begin
				off_ra = top_q - VW'(1);
			end
			S_E4: begin
				pos_ra = VW'(tgt_rd);
				dist_ra = VW'(tgt_rd);
			end
			S_E6: begin
				if (alu_less) begin
					dist_we = 1'b1;
					pred_we = 1'b1;
					dist_wa = VW'(t_q);
					pred_wa = VW'(t_q);
					dist_wd = sum_q;
					pred_wd = {1'b0, top_q};
				end
			end
			S_SU0: begin
				heap_ra_a = VW'((i_q - VW'(1)) >> 1);
				if (i_q == '0) begin
					heap_we = 1'b1;
					pos_we = 1'b1;
					pos_wa = e_q[VW-1:0];
				end
			end
			S_SU1: begin
				heap_we = 1'b1;
				pos_we = 1'b1;
				if (alu_less) begin
					heap_wd = heap_rd_a;
					pos_wa = heap_rd_a[VW-1:0];
				end else begin
					pos_wa = e_q[VW-1:0];
				end
			end
			default: begin
				off_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (off_we) begin
			off_mem[off_wa] <= cmd.edge_end_offset;
		end
		off_rd <= off_mem[off_ra];
	end

	always_ff @(posedge clk) begin
		if (edge_we) begin
			tgt_mem[edge_wa] <= cmd.edge_target;
			wgt_mem[edge_wa] <= cmd.edge_weight;
		end
		tgt_rd <= tgt_mem[edge_ra];
		wgt_rd <= wgt_mem[edge_ra];
	end

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[dist_wa] <= dist_wd;
		end
		dist_rd <= dist_mem[dist_ra];
	end

	always_ff @(posedge clk) begin
		if (pred_we) begin
			pred_mem[pred_wa] <= pred_wd;
		end
		pred_rd <= pred_mem[pred_ra];
	end

	always_ff @(posedge clk) begin
		if (heap_we) begin
			heap_mem[heap_wa] <= heap_wd;
		end
		heap_rd_a <= heap_mem[heap_ra_a];
		heap_rd_b <= heap_mem[heap_ra_b];
	end

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[pos_wa] <= pos_wd;
		end
		pos_rd <= pos_mem[pos_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= 11'd1;
			src_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_VERTEX_COUNT) begin
				vcount_q <= cfg_data[10:0];
			end else if (cfg_index == CFG_SOURCE_VERTEX) begin
				src_q <= cfg_data[VTX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				rd_oor_q <= 32'(cmd.vertex_index) >= MAX_VERTICES;
			end
			S_POP1: begin
				top_q <= heap_rd_a[VW-1:0];
				c_q <= heap_rd_a[HEW-1:VW];
				e_q <= heap_rd_b;
				i_q <= '0;
			end
			S_SD0: begin
				l_q <= l_w;
			end
			S_SD1: begin
				if ((l_q + LW'(1)) < LW'(hs_q) && alu_less) begin
					ch_q <= heap_rd_b;
					ci_q <= VW'(l_q + LW'(1));
				end else begin
					ch_q <= heap_rd_a;
					ci_q <= VW'(l_q);
				end
			end
			S_SD2: begin
				if (alu_less) begin
					i_q <= ci_q;
				end
			end
			S_E1: begin
				end_q <= off_clamp;
			end
			S_E2: begin
				j_q <= (top_q == '0) ? '0 : off_clamp;
			end
			S_E3: begin
				t_q <= t_q;
			end
			S_E4: begin
				t_q <= tgt_rd;
				w_q <= wgt_rd;
				if (32'(tgt_rd) >= n_full) begin
					j_q <= j_q + EN'(1);
				end
			end
			S_E5: begin
				sum_q <= alu_sum;
				dt_q <= dist_rd;
				pt_q <= pos_rd[VW-1:0];
				if (pos_rd[VW]) begin
					j_q <= j_q + EN'(1);
				end
			end
			S_E6: begin
				if (alu_less) begin
					e_q <= {sum_q, VW'(t_q)};
					i_q <= pt_q;
				end else begin
					j_q <= j_q + EN'(1);
				end
			end
			S_SU0: begin
				p_q <= VW'((i_q - VW'(1)) >> 1);
				if (i_q == '0) begin
					j_q <= j_q + EN'(1);
				end
			end
			S_SU1: begin
				if (alu_less) begin
					i_q <= p_q;
				end else begin
					j_q <= j_q + EN'(1);
				end
			end
			default: begin
				rd_oor_q <= rd_oor_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE) begin
			res_q.result_kind <= KIND_RUN_DONE;
			res_q.distance <= '0;
			res_q.predecessor <= '0;
			res_q.predecessor_valid <= 1'b0;
			res_q.settled_count <= 11'(settled_q);
		end else begin
			res_q.result_kind <= KIND_READ;
			res_q.distance <= rd_oor_q ? UNREACHED : dist_rd;
			res_q.predecessor <= (rd_oor_q || pred_rd[VW]) ? '0 : VTX_W'(pred_rd[VW-1:0]);
			res_q.predecessor_valid <= !rd_oor_q && !pred_rd[VW];
			res_q.settled_count <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			run_q <= 1'b0;
			clr_q <= '0;
			hs_q <= '0;
			settled_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (state_q == S_RD) || (state_q == S_DONE);
			unique case (state_q)
				S_IDLE: begin
					if (accept && cmd.mode == MODE_RUN) begin
						state_q <= S_CLR;
						run_q <= 1'b1;
						clr_q <= '0;
					end else if (accept && cmd.mode == MODE_READ) begin
						state_q <= S_RD;
					end
				end
				S_CLR: begin
					clr_q <= clr_q + VW'(1);
					if (clr_q == VW'(MAX_VERTICES - 1)) begin
						if (run_q) begin
							hs_q <= n_w;
							settled_q <= '0;
							state_q <= S_POP0;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RD: begin
					state_q <= S_IDLE;
				end
				S_DONE: begin
					hs_q <= '0;
					run_q <= 1'b0;
					state_q <= S_IDLE;
				end
				S_POP0: begin
					state_q <= (hs_q == '0) ? S_DONE : S_POP1;
				end
				S_POP1: begin
					hs_q <= hs_q - NW'(1);
					if (heap_rd_a[HEW-1:VW] == UNREACHED) begin
						state_q <= S_DONE;
					end else begin
						settled_q <= settled_q + NW'(1);
						state_q <= (hs_q == NW'(1)) ? S_E0 : S_SD0;
					end
				end
				S_SD0: begin
					state_q <= (LW'(hs_q) <= l_w) ? S_E0 : S_SD1;
				end
				S_SD1: begin
					state_q <= S_SD2;
				end
				S_SD2: begin
					state_q <= alu_less ? S_SD0 : S_E0;
				end
				S_E0: begin
					state_q <= S_E1;
				end
				S_E1: begin
					state_q <= S_E2;
				end
				S_E2: begin
					state_q <= S_E3;
				end
				S_E3: begin
					state_q <= (j_q >= end_q) ? S_POP0 : S_E4;
				end
				S_E4: begin
					state_q <= (32'(tgt_rd) >= n_full) ? S_E3 : S_E5;
				end
				S_E5: begin
					state_q <= pos_rd[VW] ? S_E3 : S_E6;
				end
				S_E6: begin
					state_q <= alu_less ? S_SU0 : S_E3;
				end
				S_SU0: begin
					state_q <= (i_q == '0) ? S_E3 : S_SU1;
				end
				S_SU1: begin
					state_q <= alu_less ? S_SU0 : S_E3;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`DSP_ASSERT_NXT(a_strobe_single, result_valid, !result_valid)
	`DSP_ASSERT_NXT(a_run_busy, accept && cmd.mode == MODE_RUN, busy)
	`DSP_ASSERT_IMP(a_heap_bound, 1'b1, 32'(hs_q) <= MAX_VERTICES)
	`DSP_ASSERT_IMP(a_run_fields, result_valid && result.result_kind == KIND_RUN_DONE,
		result.distance == '0 && !result.predecessor_valid)

endmodule
